[design/sacc_pkg.sv]
// Shared constants and controller/datapath interface types for the statistics accumulator.
`timescale 1ns / 1ps
`default_nettype none
package sacc_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COUNT_BITS_DEF  = 27;

   localparam int W_SMP   = 16;
   localparam int W_TOTAL = 43;
   localparam int W_COUNT = 27;
   localparam int W_MEAN  = 32;
   localparam int W_VAR   = 46;
   localparam int W_STD   = 23;
   localparam int W_TDATA = 208;

   localparam int FRAC_BITS  = 16;
   localparam int SQRT_STEPS = W_VAR / 2;

   typedef struct packed {
      logic accept_en;
      logic div_mean;
      logic div_var;
      logic take_mean;
      logic take_a;
      logic mul;
      logic var_calc;
      logic sqrt_start;
      logic load_out;
   } sacc_cmd_type;

   typedef struct packed {
      logic last_taken;
      logic div_busy;
      logic sqrt_busy;
      logic out_free;
   } sacc_sts_type;

endpackage
`default_nettype wire

[design/sacc_ctrl.sv]
// Sequencer for accumulation, the two divides, variance and square root.
`timescale 1ns / 1ps
`default_nettype none
module sacc_ctrl import sacc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  sacc_sts_type sts,
   output sacc_cmd_type cmd
);

   localparam logic [3:0] S_ACC     = 4'd0;
   localparam logic [3:0] S_DSTART  = 4'd1;
   localparam logic [3:0] S_DMEAN   = 4'd2;
   localparam logic [3:0] S_DVAR    = 4'd3;
   localparam logic [3:0] S_MUL     = 4'd4;
   localparam logic [3:0] S_VAR     = 4'd5;
   localparam logic [3:0] S_SQSTART = 4'd6;
   localparam logic [3:0] S_SQRT    = 4'd7;
   localparam logic [3:0] S_OUT     = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_ACC: begin
            cmd.accept_en = 1'b1;
            if (sts.last_taken) state_in = S_DSTART;
         end
         S_DSTART: begin
            cmd.div_mean = 1'b1;
            state_in     = S_DMEAN;
         end
         S_DMEAN: begin
            if (!sts.div_busy) begin
               cmd.take_mean = 1'b1;
               cmd.div_var   = 1'b1;
               state_in      = S_DVAR;
            end
         end
         S_DVAR: begin
            if (!sts.div_busy) begin
               cmd.take_a = 1'b1;
               state_in   = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_VAR;
         end
         S_VAR: begin
            cmd.var_calc = 1'b1;
            state_in     = S_SQSTART;
         end
         S_SQSTART: begin
            cmd.sqrt_start = 1'b1;
            state_in       = S_SQRT;
         end
         S_SQRT: begin
            if (!sts.sqrt_busy) state_in = S_OUT;
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_ACC;
            end
         end
         default: state_in = S_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_ACC;
      else       state_ff <= state_in;
   end

endmodule
`default_nettype wire

[design/sacc_dp.sv]
// Accumulators, shared restoring divider, squarer, variance and square-root datapath.
`timescale 1ns / 1ps
`default_nettype none
module sacc_dp import sacc_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  sacc_cmd_type            cmd,
   output sacc_sts_type            sts,
   input  wire logic               req_tvalid,
   input  wire logic [W_SMP-1:0]   req_tdata,
   input  wire logic               req_tlast,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [W_TDATA-1:0]      rsp_tdata,
   output logic [0:0]              rsp_tuser
);

   localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
   localparam int SQ_W  = 2 * SAMPLE_BITS - 1 + COUNT_BITS;
   localparam int DIV_W = SQ_W + FRAC_BITS;
   localparam int A_W   = 2 * SAMPLE_BITS + 15;
   localparam int DC_W  = $clog2(DIV_W + 1);
   localparam int SC_W  = $clog2(SQRT_STEPS + 1);
   localparam int VD_W  = 48;
   localparam int REM_W = W_STD + 3;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic signed [W_SMP-1:0] SMP_MAX = W_SMP'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [W_SMP-1:0] SMP_MIN = W_SMP'(-(1 << (SAMPLE_BITS - 1)));

   // accumulation
   logic signed [SAMPLE_BITS-1:0]   s_raw;
   logic signed [W_SMP-1:0]         s_ext;
   logic [SAMPLE_BITS-1:0]          s_mag;
   logic [2*SAMPLE_BITS-1:0]        s_sq;
   logic                            room, take;
   logic signed [W_SMP-1:0]         min_ff, max_ff, n_min, n_max;
   logic signed [SUM_W-1:0]         sum_ff, n_sum;
   logic [SQ_W-1:0]                 sq_ff, n_sq;
   logic [COUNT_BITS-1:0]           cnt_ff, n_cnt;
   logic                            ovf_ff, n_ovf;

   assign s_raw = signed'(req_tdata[SAMPLE_BITS-1:0]);
   assign s_ext = W_SMP'(s_raw);
   assign s_mag = s_raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(-s_raw) : unsigned'(s_raw);
   assign s_sq  = (2 * SAMPLE_BITS)'(s_mag) * (2 * SAMPLE_BITS)'(s_mag);
   assign room  = (cnt_ff != CNT_MAX);
   assign take  = cmd.accept_en & req_tvalid;
   assign n_min = (s_ext < min_ff) ? s_ext : min_ff;
   assign n_max = (s_ext > max_ff) ? s_ext : max_ff;
   assign n_sum = room ? sum_ff + SUM_W'(s_raw) : sum_ff;
   assign n_sq  = room ? sq_ff + SQ_W'(s_sq) : sq_ff;
   assign n_cnt = room ? cnt_ff + 1'b1 : cnt_ff;
   assign n_ovf = ovf_ff | ~room;

   // snapshot of the closed set
   logic signed [W_SMP-1:0] c_min_ff, c_max_ff;
   logic signed [SUM_W-1:0] c_sum_ff;
   logic [SQ_W-1:0]         c_sq_ff;
   logic [COUNT_BITS-1:0]   c_cnt_ff;
   logic                    c_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset || (take && req_tlast)) begin
         min_ff <= SMP_MAX;
         max_ff <= SMP_MIN;
         sum_ff <= '0;
         sq_ff  <= '0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (take) begin
         min_ff <= n_min;
         max_ff <= n_max;
         sum_ff <= n_sum;
         sq_ff  <= n_sq;
         cnt_ff <= n_cnt;
         ovf_ff <= n_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_tlast) begin
         c_min_ff <= n_min;
         c_max_ff <= n_max;
         c_sum_ff <= n_sum;
         c_sq_ff  <= n_sq;
         c_cnt_ff <= n_cnt;
         c_ovf_ff <= n_ovf;
      end
   end

   // restoring divider, one quotient bit per cycle
   logic [DIV_W-1:0]      dq_ff;
   logic [COUNT_BITS-1:0] dr_ff;
   logic [DC_W-1:0]       dc_ff;
   logic [COUNT_BITS:0]   d_sh, d_diff;
   logic                  d_ge;
   logic [SUM_W-1:0]      sum_mag;

   assign sum_mag = c_sum_ff[SUM_W-1] ? unsigned'(-c_sum_ff) : unsigned'(c_sum_ff);
   assign d_sh    = {dr_ff, dq_ff[DIV_W-1]};
   assign d_diff  = d_sh - {1'b0, c_cnt_ff};
   assign d_ge    = (d_sh >= {1'b0, c_cnt_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_ff <= '0;
      end else if (cmd.div_mean || cmd.div_var) begin
         dc_ff <= DC_W'(DIV_W);
      end else if (dc_ff != '0) begin
         dc_ff <= dc_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_mean) begin
         dq_ff <= DIV_W'({sum_mag, {FRAC_BITS{1'b0}}});
         dr_ff <= '0;
      end else if (cmd.div_var) begin
         dq_ff <= {c_sq_ff, {FRAC_BITS{1'b0}}};
         dr_ff <= '0;
      end else if (dc_ff != '0) begin
         dq_ff <= {dq_ff[DIV_W-2:0], d_ge};
         dr_ff <= d_ge ? d_diff[COUNT_BITS-1:0] : d_sh[COUNT_BITS-1:0];
      end
   end

   // mean, squared mean and variance
   logic [W_MEAN-1:0]          mmag_ff;
   logic signed [W_MEAN-1:0]   mean_ff;
   logic [A_W-1:0]             a_ff;
   logic [2*W_MEAN-1:0]        p_ff;
   logic [W_VAR-1:0]           var_ff;
   logic [VD_W-1:0]            a_x, b_x, v_diff;

   assign a_x    = VD_W'(a_ff);
   assign b_x    = p_ff[2*W_MEAN-1:FRAC_BITS];
   assign v_diff = a_x - b_x;

   always_ff @(posedge clock) begin
      if (cmd.take_mean) begin
         mmag_ff <= dq_ff[W_MEAN-1:0];
         mean_ff <= c_sum_ff[SUM_W-1] ? signed'(-dq_ff[W_MEAN-1:0])
                                      : signed'(dq_ff[W_MEAN-1:0]);
      end
      if (cmd.take_a) a_ff <= dq_ff[A_W-1:0];
      if (cmd.mul)    p_ff <= (2 * W_MEAN)'(mmag_ff) * (2 * W_MEAN)'(mmag_ff);
      if (cmd.var_calc) begin
         if (a_x <= b_x)                     var_ff <= '0;
         else if (v_diff[VD_W-1:W_VAR] != '0) var_ff <= '1;
         else                                var_ff <= v_diff[W_VAR-1:0];
      end
   end

   // digit-by-digit square root, two radicand bits per cycle
   logic [W_VAR-1:0] sv_ff;
   logic [REM_W-1:0] srem_ff, s_sh, s_trial;
   logic [W_STD-1:0] root_ff;
   logic [SC_W-1:0]  sc_ff;
   logic             s_ge;

   assign s_sh    = {srem_ff[REM_W-3:0], sv_ff[W_VAR-1:W_VAR-2]};
   assign s_trial = {1'b0, root_ff, 2'b01};
   assign s_ge    = (s_sh >= s_trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff <= '0;
      end else if (cmd.sqrt_start) begin
         sc_ff <= SC_W'(SQRT_STEPS);
      end else if (sc_ff != '0) begin
         sc_ff <= sc_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         sv_ff   <= var_ff;
         srem_ff <= '0;
         root_ff <= '0;
      end else if (sc_ff != '0) begin
         sv_ff   <= {sv_ff[W_VAR-3:0], 2'b00};
         srem_ff <= s_ge ? s_sh - s_trial : s_sh;
         root_ff <= {root_ff[W_STD-2:0], s_ge};
      end
   end

   // result register
   logic                 rsp_tvalid_ff;
   logic [W_TDATA-1:0]   rsp_tdata_ff;
   logic                 rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset)             rsp_tvalid_ff <= 1'b0;
      else if (cmd.load_out) rsp_tvalid_ff <= 1'b1;
      else if (rsp_tready)   rsp_tvalid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_tdata_ff <= W_TDATA'({root_ff, var_ff, mean_ff, W_COUNT'(c_cnt_ff),
                                   W_TOTAL'(c_sum_ff), c_max_ff, c_min_ff});
         rsp_ovf_ff   <= c_ovf_ff;
      end
   end

   assign rsp_tvalid     = rsp_tvalid_ff;
   assign rsp_tdata      = rsp_tdata_ff;
   assign rsp_tuser      = rsp_ovf_ff;

   assign sts.last_taken = take & req_tlast;
   assign sts.div_busy   = (dc_ff != '0);
   assign sts.sqrt_busy  = (sc_ff != '0);
   assign sts.out_free   = ~rsp_tvalid_ff | rsp_tready;

endmodule
`default_nettype wire

[design/stream_statistics_accumulator_top.sv]
// Top level of the stream statistics accumulator (min, max, mean, variance, deviation).
// Throughput: one sample per cycle while a set is accumulating.
// After the transaction marked tlast, no sample is taken until the result is loaded:
// two bit-serial divides on the shared divider, each giving DIV_W quotient bits,
// DIV_W = 2*SAMPLE_BITS - 1 + COUNT_BITS + 16 (74 by default), and a 23-step square root.
// rsp_tvalid rises with that load, which waits while a held result is stalled by rsp_tready.
// Reset: synchronous, active high; clears accumulators, sequencer and result valid.
`timescale 1ns / 1ps
`default_nettype none
module stream_statistics_accumulator_top import sacc_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request stream
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [W_SMP-1:0]   req_tdata,   // sample[15:0]
   input  wire logic               req_tlast,   // last sample of the set
   // result stream
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [W_TDATA-1:0]      rsp_tdata,   // minimum[15:0], maximum[31:16],
                                                // total[74:32], item_count[101:75],
                                                // mean_q16[133:102], variance_q16[179:134],
                                                // std_dev_q8[202:180], zero pad
   output logic [0:0]              rsp_tuser    // overflow[0]
);

   sacc_cmd_type cmd;
   sacc_sts_type sts;

   // Sequencer: accepts samples only while accumulating; walks the result
   // computation once per set.
   sacc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // Datapath: accumulators, divider, squarer, root unit and result register.
   sacc_dp #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   assign req_tready = cmd.accept_en;

endmodule
`default_nettype wire

[design/sacc_checker.sv]
// Port-level assertions for the statistics accumulator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sacc_checker import sacc_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_tvalid,
   input wire logic               req_tready,
   input wire logic               req_tlast,
   input wire logic               rsp_tvalid,
   input wire logic               rsp_tready,
   input wire logic [W_TDATA-1:0] rsp_tdata,
   input wire logic [0:0]         rsp_tuser
);

   logic [W_STD-1:0] std_v;
   logic [W_VAR-1:0] var_v;
   assign std_v = rsp_tdata[202:180];
   assign var_v = rsp_tdata[179:134];

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_data_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("sample taken during result computation");

   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (W_VAR'(std_v) * W_VAR'(std_v)) <= var_v)
      else $error("deviation exceeds root of variance");

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= $signed(rsp_tdata[31:16]))
                     && (rsp_tdata[101:75] != '0))
      else $error("bad minimum, maximum or count");

endmodule

bind stream_statistics_accumulator_top sacc_checker u_sacc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

[tb/tb_stream_statistics_accumulator_top.sv]
// Testbench for the stream statistics accumulator: sets of random samples, predicted stats.
`timescale 1ns / 1ps

import sacc_pkg::*;

typedef struct {
   logic [W_SMP-1:0]   minimum;
   logic [W_SMP-1:0]   maximum;
   logic [W_TOTAL-1:0] total;
   logic [W_COUNT-1:0] item_count;
   logic [W_MEAN-1:0]  mean_q16;
   logic [W_VAR-1:0]   variance_q16;
   logic [W_STD-1:0]   std_dev_q8;
   logic               overflow;
} set_stats_type;

class stats_scoreboard;
   longint          acc_min, acc_max, acc_sum;
   longint unsigned acc_sq, acc_cnt;
   bit              acc_ovf;
   set_stats_type   pending_stats[$];
   int              errors;

   function new();
      clear_set();
      errors = 0;
   endfunction

   function void clear_set();
      acc_min = 32767;
      acc_max = -32768;
      acc_sum = 0;
      acc_sq  = 0;
      acc_cnt = 0;
      acc_ovf = 0;
   endfunction

   function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // accepted sample transaction; a marked sample closes the set
   function void note_sample(logic [15:0] raw, bit last);
      longint s, mean;
      longint unsigned q, r, a, bb, mmag, variance, root;
      set_stats_type e;
      s = longint'($signed(raw));
      if (s < acc_min) acc_min = s;
      if (s > acc_max) acc_max = s;
      if (acc_cnt < (64'd1 << W_COUNT) - 1) begin
         acc_sum += s;
         acc_sq  += longint'(s * s);
         acc_cnt++;
      end else begin
         acc_ovf = 1;
      end
      if (!last) return;
      mean = 0;
      variance = 0;
      if (acc_cnt != 0) begin
         q = acc_sq / acc_cnt;
         r = acc_sq % acc_cnt;
         mean = (acc_sum * 65536) / longint'(acc_cnt);
         a = (q << FRAC_BITS) + ((r << FRAC_BITS) / acc_cnt);
         mmag = mean < 0 ? -mean : mean;
         bb = (mmag * mmag) >> FRAC_BITS;
         variance = a > bb ? a - bb : 0;
         if (variance > (64'd1 << W_VAR) - 1) variance = (64'd1 << W_VAR) - 1;
      end
      root = int_sqrt(variance);
      e.minimum      = acc_min[W_SMP-1:0];
      e.maximum      = acc_max[W_SMP-1:0];
      e.total        = acc_sum[W_TOTAL-1:0];
      e.item_count   = acc_cnt[W_COUNT-1:0];
      e.mean_q16     = mean[W_MEAN-1:0];
      e.variance_q16 = variance[W_VAR-1:0];
      e.std_dev_q8   = root[W_STD-1:0];
      e.overflow     = acc_ovf;
      pending_stats.push_back(e);
      clear_set();
   endfunction

   task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task check_result(logic [W_TDATA-1:0] d, logic [0:0] u);
      set_stats_type e;
      if (pending_stats.size() == 0) begin
         report_mismatch("unexpected result", d[63:0], 0);
         return;
      end
      e = pending_stats.pop_front();
      if (d[15:0] !== e.minimum)        report_mismatch("minimum", d[15:0], e.minimum);
      if (d[31:16] !== e.maximum)       report_mismatch("maximum", d[31:16], e.maximum);
      if (d[74:32] !== e.total)         report_mismatch("total", d[74:32], e.total);
      if (d[101:75] !== e.item_count)   report_mismatch("item_count", d[101:75], e.item_count);
      if (d[133:102] !== e.mean_q16)    report_mismatch("mean_q16", d[133:102], e.mean_q16);
      if (d[179:134] !== e.variance_q16)
         report_mismatch("variance_q16", d[179:134], e.variance_q16);
      if (d[202:180] !== e.std_dev_q8)  report_mismatch("std_dev_q8", d[202:180], e.std_dev_q8);
      if (u[0] !== e.overflow)          report_mismatch("overflow", u[0], e.overflow);
   endtask
endclass

module tb_stream_statistics_accumulator_top;
   localparam int SET_LATENCY = 200;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_tvalid = 0;
   logic               req_tready;
   logic [W_SMP-1:0]   req_tdata = '0;
   logic               req_tlast = 0;
   logic               rsp_tvalid;
   logic               rsp_tready = 0;
   logic [W_TDATA-1:0] rsp_tdata;
   logic [0:0]         rsp_tuser;

   stats_scoreboard sb = new();
   int send_idle_pct = 0;   // chance of a gap before each sample
   int recv_stall_pct = 0;  // chance of ready low per cycle
   int hold_off_cycles = 0; // long receiver hold-off, taken by the receiver process

   stream_statistics_accumulator_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #6 clock = ~clock;

   // offer one sample and wait for its transaction
   task send_sample(logic [15:0] s, bit last);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= s;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_sample(s, last);
   endtask

   task send_set(int len);
      for (int i = 0; i < len; i++) send_sample(16'($urandom), i == len - 1);
   endtask

   // sender pauses until every expected result is back, then lets the block settle
   task drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending_stats.size() != 0) @(posedge clock);
      repeat (SET_LATENCY) @(posedge clock);
   endtask

   // receiver: check at each edge, then choose ready for the next one
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
         end
      end
   end

   initial begin
      int sent, len;
      bit held;
      held = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, single-sample sets, mixed signs
      send_sample(16'h7fff, 1);
      send_sample(16'h8000, 1);
      send_sample(16'h0000, 1);
      send_sample(16'h8000, 0);
      send_sample(16'h7fff, 1);
      send_sample(16'h8000, 0);
      send_sample(16'h8000, 0);
      send_sample(16'h8000, 1);
      send_sample(16'h7fff, 0);
      send_sample(16'h7fff, 0);
      send_sample(16'hffff, 1);
      send_sample(16'h0001, 0);
      send_sample(16'h0002, 0);
      send_sample(16'hfffd, 1);
      send_sample(16'h5555, 0);
      send_sample(16'haaaa, 1);
      drain();

      // random sets, three idling phases
      sent = 0;
      while (sent < 500) begin
         if (sent < 170) begin
            send_idle_pct = 11;
            recv_stall_pct = 73;
         end else if (sent < 340) begin
            send_idle_pct = 73;
            recv_stall_pct = 11;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         len = ($urandom_range(99) < 5) ? $urandom_range(40, 120) : $urandom_range(1, 6);
         // one long receiver hold-off while the sender keeps offering
         if (!held && sent >= 250) begin
            hold_off_cycles = 600;
            held = 1;
         end
         send_set(len);
         sent += len;
         if ($urandom_range(99) < 3) drain();
      end
      drain();

      if (sb.errors == 0 && sb.pending_stats.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #(12 * 1000000);
      $display("FAILURE");
      $finish;
   end
endmodule
